/* src/mafr_pkg.sv */
// ----------------------------------------------------------------------------
// mafr_pkg: shared definitions for the audio frame ring
// Field widths, command and status codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package mafr_pkg;

    // field widths
    localparam int CMD_W    = 3;
    localparam int SMP_W    = 32;
    localparam int CNT_W    = 10;
    localparam int CH_W     = 4;
    localparam int CAPF_W   = 10;
    localparam int ST_W     = 2;
    localparam int FCNT_W   = 10;
    localparam int CONS_W   = 48;

    // stream packing
    localparam int IN_TDATA_W   = 48;   // sample_in, frame_count, zero pad
    localparam int IN_TUSER_W   = CMD_W;
    localparam int OUT_TDATA_W  = 104;  // sample, can_read, can_write, consumed, pad
    localparam int OUT_TUSER_W  = ST_W;
    localparam int OUT_PAD_W    = OUT_TDATA_W - SMP_W - 2 * FCNT_W - CONS_W;

    // configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = (CH_W > CAPF_W) ? CH_W : CAPF_W;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

    // parameter defaults
    localparam int DEF_MAX_FRAMES   = 512;
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_MAX_BURST    = 8;

    // register reset values
    localparam logic [CH_W-1:0]   RST_CHANNELS = 4'd2;
    localparam logic [CAPF_W-1:0] RST_CAPF     = 10'd512;

    // commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SKIP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // result status
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
    localparam logic [ST_W-1:0] ST_OVER  = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd3;

endpackage

/* src/mafr_div.sv */
// ----------------------------------------------------------------------------
// mafr_div: bit-serial divider by the channel count
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mafr_div #(
    parameter int DW = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DW-1:0]             i_dividend,
    input  logic [mafr_pkg::CH_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [DW-1:0]             o_quotient
);

    localparam int REM_W = mafr_pkg::CH_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic [REM_W-1:0] r_rem;
    logic [DW-1:0]    r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_div;
    logic             r_busy;
    logic             r_done;

    logic [REM_W:0]   shifted;
    logic [REM_W+1:0] diff;
    logic [REM_W-1:0] n_rem;
    logic [DW-1:0]    n_quo;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
        if (!diff[REM_W+1]) begin
            n_rem = diff[REM_W-1:0];
            n_quo = {r_quo[DW-2:0], 1'b1};
        end else begin
            n_rem = shifted[REM_W-1:0];
            n_quo = {r_quo[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_cnt  <= CNT_W'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* src/multichannel_audio_frame_ring_top.sv */
// ----------------------------------------------------------------------------
// multichannel_audio_frame_ring_top: circular buffer of interleaved samples
// Stores samples, hands out whole frames on read or peek, drops frames on
// skip, and reports readable, writable and consumed frame counts.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  --------  ---  -----------------------------  ------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: command
//                                                tdata: sample_in, frame_count
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser: status, tlast: last
//                                                tdata: sample_out,
//                                                frames_can_read,
//                                                frames_can_write,
//                                                frames_consumed
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  Sequence: an item passes S_MUL and S_EXEC, then the one OCC_W-bit divider
//  (OCC_W = 13 by default) runs twice, for frames readable and then frames
//  writable, before a single result loads the output register; a read or peek
//  instead sends its samples via the registered memory read port. Input is not ready meanwhile.
//  Reset: synchronous, active low; empty buffer, 2 channels, 512 frames.
//  Stalls: a waiting result does not block the next item; the next result
//  holds until the output register is free.
//
module multichannel_audio_frame_ring_top #(
    parameter int MAX_FRAMES       = mafr_pkg::DEF_MAX_FRAMES,
    parameter int MAX_CHANNELS     = mafr_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_BURST_FRAMES = mafr_pkg::DEF_MAX_BURST
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] sample_in, [41:32] frame_count, [47:42] zero
    input  logic [mafr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [2:0] command
    input  logic [mafr_pkg::IN_TUSER_W-1:0]     s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] sample_out, [41:32] frames_can_read, [51:42] frames_can_write,
    // [99:52] frames_consumed, [103:100] zero
    output logic [mafr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [mafr_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                m_axis_tlast,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mafr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mafr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CH_W   = mafr_pkg::CH_W;
    localparam int CAPF_W = mafr_pkg::CAPF_W;
    localparam int CNT_W  = mafr_pkg::CNT_W;
    localparam int SMP_W  = mafr_pkg::SMP_W;
    localparam int CMD_W  = mafr_pkg::CMD_W;
    localparam int ST_W   = mafr_pkg::ST_W;
    localparam int FCNT_W = mafr_pkg::FCNT_W;
    localparam int CONS_W = mafr_pkg::CONS_W;

    localparam int DEPTH  = MAX_FRAMES * MAX_CHANNELS;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int FR_W   = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W  = ((FR_W > CAPF_W) ? FR_W : CAPF_W) + 1;
    localparam int N_W    = CNT_W + CH_W;
    localparam int SUM_W  = ((N_W > OCC_W) ? N_W : OCC_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_EXEC,
        S_DIVA,
        S_DIVB,
        S_DIVC,
        S_LOAD1,
        S_RD,
        S_LOADS
    } t_state;

    t_state             r_state;

    // configuration
    logic [CH_W-1:0]    r_chan;
    logic [CAPF_W-1:0]  r_capf;

    // buffer state
    logic [IDX_W-1:0]   r_ridx;
    logic [IDX_W-1:0]   r_widx;
    logic [OCC_W-1:0]   r_occ;
    logic [CONS_W-1:0]  r_cons;

    // current item
    logic [CMD_W-1:0]   r_cmd;
    logic [SMP_W-1:0]   r_smp;
    logic [CNT_W-1:0]   r_cnt;
    logic [N_W-1:0]     r_n;
    logic [ST_W-1:0]    r_status;
    logic               r_burst;
    logic [IDX_W-1:0]   r_idx;
    logic [N_W-1:0]     r_left;
    logic [FCNT_W-1:0]  r_fcr;
    logic [FCNT_W-1:0]  r_fcw;

    // output register
    logic               r_out_valid;
    logic [SMP_W-1:0]   r_out_smp;
    logic               r_out_last;
    logic [ST_W-1:0]    r_out_st;
    logic [FCNT_W-1:0]  r_out_fcr;
    logic [FCNT_W-1:0]  r_out_fcw;
    logic [CONS_W-1:0]  r_out_cons;

    // sample memory
    logic [SMP_W-1:0]   r_mem [DEPTH];
    logic [SMP_W-1:0]   r_rdata;
    logic               mem_we;

    // derived values
    logic [CH_W-1:0]    ch_eff;
    logic [FR_W-1:0]    capf_eff;
    logic [OCC_W-1:0]   cap;
    logic               full;
    logic               under;
    logic               bad_cnt;
    logic [SUM_W-1:0]   rsum;
    logic [IDX_W-1:0]   ridx_adv;
    logic [SUM_W-1:0]   wsum;
    logic [IDX_W-1:0]   widx_adv;
    logic [SUM_W-1:0]   isum;
    logic [IDX_W-1:0]   idx_adv;
    logic               out_free;
    logic               in_acc;
    logic               cfg_acc;

    logic               div_start;
    logic [OCC_W-1:0]   div_dividend;
    logic               div_done;
    logic [OCC_W-1:0]   div_quo;

    // clamp out-of-range configuration values
    always_comb begin
        if (r_chan == '0) begin
            ch_eff = CH_W'(1);
        end else if (r_chan > CH_W'(MAX_CHANNELS)) begin
            ch_eff = CH_W'(MAX_CHANNELS);
        end else begin
            ch_eff = r_chan;
        end

        if (r_capf == '0) begin
            capf_eff = FR_W'(1);
        end else if (CMP_W'(r_capf) > CMP_W'(MAX_FRAMES)) begin
            capf_eff = FR_W'(MAX_FRAMES);
        end else begin
            capf_eff = FR_W'(r_capf);
        end
        cap = OCC_W'(capf_eff) * OCC_W'(ch_eff);
    end

    // checks and wrapped pointer advances
    always_comb begin
        full    = (r_occ >= cap);
        under   = (SUM_W'(r_n) > SUM_W'(r_occ));
        bad_cnt = (r_cnt == '0) || (SUM_W'(r_cnt) > SUM_W'(MAX_BURST_FRAMES));

        rsum     = SUM_W'(r_ridx) + SUM_W'(r_n);
        ridx_adv = (rsum >= SUM_W'(cap)) ? IDX_W'(rsum - SUM_W'(cap)) : IDX_W'(rsum);

        wsum     = SUM_W'(r_widx) + SUM_W'(1);
        widx_adv = (wsum >= SUM_W'(cap)) ? '0 : IDX_W'(wsum);

        isum     = SUM_W'(r_idx) + SUM_W'(1);
        idx_adv  = (isum >= SUM_W'(cap)) ? '0 : IDX_W'(isum);
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign mem_we        = (r_state == S_EXEC) && (r_cmd == mafr_pkg::CMD_WRITE) && !full;

    // one divider computes frames readable, then frames writable
    assign div_start    = (r_state == S_DIVA) || ((r_state == S_DIVB) && div_done);
    assign div_dividend = (r_state == S_DIVA) ? r_occ : (cap - r_occ);

    mafr_div #(
        .DW         (OCC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (ch_eff),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_widx] <= r_smp;
        end
        r_rdata <= r_mem[r_idx];
    end

    // sequencer, buffer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= mafr_pkg::RST_CHANNELS;
            r_capf      <= mafr_pkg::RST_CAPF;
            r_ridx      <= '0;
            r_widx      <= '0;
            r_occ       <= '0;
            r_cons      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken; a reload below overrides this
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        unique case (i_cfg_index)
                            mafr_pkg::REG_CHANNELS: r_chan <= i_cfg_data[CH_W-1:0];
                            mafr_pkg::REG_CAPACITY: r_capf <= i_cfg_data[CAPF_W-1:0];
                        endcase
                        // any register write empties the buffer
                        r_ridx <= '0;
                        r_widx <= '0;
                        r_occ  <= '0;
                        r_cons <= '0;
                    end else if (in_acc) begin
                        r_cmd   <= s_axis_tuser[CMD_W-1:0];
                        r_smp   <= s_axis_tdata[SMP_W-1:0];
                        r_cnt   <= s_axis_tdata[SMP_W +: CNT_W];
                        r_state <= S_MUL;
                    end
                end

                S_MUL: begin
                    r_n     <= N_W'(r_cnt) * N_W'(ch_eff);
                    r_state <= S_EXEC;
                end

                S_EXEC: begin
                    r_burst  <= 1'b0;
                    r_status <= mafr_pkg::ST_OK;
                    unique case (r_cmd) inside
                        mafr_pkg::CMD_WRITE: begin
                            if (full) begin
                                r_status <= mafr_pkg::ST_OVER;
                            end else begin
                                r_widx <= widx_adv;
                                r_occ  <= r_occ + OCC_W'(1);
                            end
                        end
                        mafr_pkg::CMD_READ, mafr_pkg::CMD_PEEK: begin
                            if (bad_cnt) begin
                                r_status <= mafr_pkg::ST_BAD;
                            end else if (under) begin
                                r_status <= mafr_pkg::ST_UNDER;
                            end else begin
                                // emit from the read pointer as it stands now
                                r_burst <= 1'b1;
                                r_idx   <= r_ridx;
                                r_left  <= r_n;
                                if (r_cmd == mafr_pkg::CMD_READ) begin
                                    r_ridx <= ridx_adv;
                                    r_occ  <= r_occ - OCC_W'(r_n);
                                    r_cons <= r_cons + CONS_W'(r_cnt);
                                end
                            end
                        end
                        mafr_pkg::CMD_SKIP: begin
                            if (under) begin
                                r_status <= mafr_pkg::ST_UNDER;
                            end else begin
                                r_ridx <= ridx_adv;
                                r_occ  <= r_occ - OCC_W'(r_n);
                                r_cons <= r_cons + CONS_W'(r_cnt);
                            end
                        end
                        mafr_pkg::CMD_CLEAR: begin
                            r_ridx <= '0;
                            r_widx <= '0;
                            r_occ  <= '0;
                            r_cons <= '0;
                        end
                        default: begin
                            // unused codes change nothing
                        end
                    endcase
                    r_state <= S_DIVA;
                end

                S_DIVA: begin
                    r_state <= S_DIVB;
                end

                S_DIVB: begin
                    if (div_done) begin
                        r_fcr   <= FCNT_W'(div_quo);
                        r_state <= S_DIVC;
                    end
                end

                S_DIVC: begin
                    if (div_done) begin
                        r_fcw   <= FCNT_W'(div_quo);
                        r_state <= r_burst ? S_RD : S_LOAD1;
                    end
                end

                S_LOAD1: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_smp   <= '0;
                        r_out_last  <= 1'b1;
                        r_out_st    <= r_status;
                        r_out_fcr   <= r_fcr;
                        r_out_fcw   <= r_fcw;
                        r_out_cons  <= r_cons;
                        r_state     <= S_IDLE;
                    end
                end

                S_RD: begin
                    // memory read of r_idx lands in r_rdata this edge
                    r_state <= S_LOADS;
                end

                S_LOADS: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_smp   <= r_rdata;
                        r_out_last  <= (r_left == N_W'(1));
                        r_out_st    <= mafr_pkg::ST_OK;
                        r_out_fcr   <= r_fcr;
                        r_out_fcw   <= r_fcw;
                        r_out_cons  <= r_cons;
                        r_idx       <= idx_adv;
                        r_left      <= r_left - N_W'(1);
                        r_state     <= (r_left == N_W'(1)) ? S_IDLE : S_RD;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tdata  = {{mafr_pkg::OUT_PAD_W{1'b0}}, r_out_cons, r_out_fcw,
                            r_out_fcr, r_out_smp};

`ifndef SYNTHESIS
    // occupancy never exceeds the configured capacity
    a_occ_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= cap)
        else $error("occupancy above capacity");

    // both pointers stay inside the configured capacity
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SUM_W'(r_ridx) < SUM_W'(cap)) && (SUM_W'(r_widx) < SUM_W'(cap)))
        else $error("pointer outside capacity");

    // a refused command gives one result only
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != mafr_pkg::ST_OK)) |-> m_axis_tlast)
        else $error("error result not marked last");

    // the divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == S_DIVB) || (r_state == S_DIVC)))
        else $error("divider result not awaited");
`endif

endmodule
